FILE: hw/rtl/expression_tokenizer_top_macros.svh
// Assertion macros used by the tokenizer checker.
`ifndef EXPRESSION_TOKENIZER_TOP_MACROS_SVH
`define EXPRESSION_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define EXPTOK_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, off while reset is high.
`define EXPTOK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication that also holds across reset.
`define EXPTOK_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tokenizer reset check failed");

`endif

FILE: hw/rtl/exptok_pkg.sv
// Types, token codes, character constants and character classes of the tokenizer.
`default_nettype none

package exptok_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int BUNDLE_DEPTH = 5;

  localparam logic [3:0] KIND_END     = 4'd0;
  localparam logic [3:0] KIND_EQ      = 4'd1;
  localparam logic [3:0] KIND_PLUS    = 4'd2;
  localparam logic [3:0] KIND_MINUS   = 4'd3;
  localparam logic [3:0] KIND_STAR    = 4'd4;
  localparam logic [3:0] KIND_SLASH   = 4'd5;
  localparam logic [3:0] KIND_CARET   = 4'd6;
  localparam logic [3:0] KIND_LPAREN  = 4'd7;
  localparam logic [3:0] KIND_RPAREN  = 4'd8;
  localparam logic [3:0] KIND_LBRACK  = 4'd9;
  localparam logic [3:0] KIND_RBRACK  = 4'd10;
  localparam logic [3:0] KIND_NUMBER  = 4'd11;
  localparam logic [3:0] KIND_IDENT   = 4'd12;
  localparam logic [3:0] KIND_UNKNOWN = 4'd13;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_E   = 8'h45;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
  } token_t;

  // All tokens caused by one input beat, in order.
  typedef struct packed {
    logic [2:0]                     cnt;
    token_t [BUNDLE_DEPTH-1:0]      tok;
  } bundle_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_exp_mark(input logic [7:0] c);
    return (c == CH_LC_E) || (c == CH_UC_E);
  endfunction

  // Kind of a one-byte operator or bracket; KIND_END when the byte is none.
  function automatic logic [3:0] op_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      CH_EQ:     k = KIND_EQ;
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_CARET:  k = KIND_CARET;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      default:   k = KIND_END;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/exptok_lexer.sv
// Lexer state registers and the single-pass logic that turns one byte into its tokens.
`default_nettype none

module exptok_lexer
  import exptok_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] char_in,
  input  wire logic       has_char,
  input  wire logic       last,
  input  wire logic       take,
  output bundle_t         bundle
);

  localparam int PW = POSITION_BITS;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_INT     = 3'd2;
  localparam logic [2:0] MODE_FRAC    = 3'd3;
  localparam logic [2:0] MODE_EXP     = 3'd4;
  localparam logic [2:0] MODE_EXPSIGN = 3'd5;
  localparam logic [2:0] MODE_EXPDIG  = 3'd6;

  localparam logic [PW-1:0] POS_MAX  = {PW{1'b1}};
  localparam logic [PW-1:0] POS_ZERO = {PW{1'b0}};
  localparam logic [PW-1:0] POS_ONE  = {{(PW-1){1'b0}}, 1'b1};
  localparam logic [PW-1:0] POS_TWO  = {{(PW-2){1'b0}}, 2'b10};
  localparam logic [PW:0]   LEN_ZERO = {(PW+1){1'b0}};
  localparam logic [PW:0]   LEN_ONE  = {{PW{1'b0}}, 1'b1};

  typedef struct packed {
    logic [1:0]   cnt;
    token_t [2:0] tok;
  } close_t;

  logic [2:0]    mode;
  logic [PW-1:0] open_start;
  logic [PW-1:0] byte_position;
  logic          pending_sign;

  logic [2:0]    mode_next;
  logic [PW-1:0] open_start_next;
  logic [PW-1:0] byte_position_next;
  logic          pending_sign_next;

  function automatic logic [15:0] to16(input logic [PW:0] x);
    logic [PW+16:0] t;
    t = {16'b0, x};
    return t[15:0];
  endfunction

  function automatic logic [PW:0] ext(input logic [PW-1:0] x);
    return {1'b0, x};
  endfunction

  function automatic token_t mk(input logic [3:0] k, input logic [PW:0] s,
                                input logic [PW:0] l);
    token_t t;
    t.kind   = k;
    t.start  = to16(s);
    t.length = to16(l);
    return t;
  endfunction

  // Tokens left by the open token when a non-continuing byte sits at offset p.
  // An exponent mark with no digit after it is split off as an identifier,
  // and a sign after it as an operator.
  function automatic close_t close_fn(input logic [2:0] m, input logic [PW-1:0] os,
                                      input logic sg, input logic [PW-1:0] p);
    logic [PW-1:0] d;
    logic [PW-1:0] e1;
    logic [PW-1:0] e2;
    close_t        r;
    d  = p - os;
    e1 = (d >= POS_ONE) ? p - POS_ONE : os;
    e2 = (d >= POS_TWO) ? p - POS_TWO : os;
    r  = '0;
    case (m) inside
      MODE_IDENT: begin
        r.cnt    = 2'd1;
        r.tok[0] = mk(KIND_IDENT, ext(os), ext(d));
      end
      MODE_INT, MODE_FRAC, MODE_EXPDIG: begin
        r.cnt    = 2'd1;
        r.tok[0] = mk(KIND_NUMBER, ext(os), ext(d));
      end
      MODE_EXP: begin
        r.cnt    = 2'd2;
        r.tok[0] = mk(KIND_NUMBER, ext(os), ext(e1 - os));
        r.tok[1] = mk(KIND_IDENT, ext(e1), LEN_ONE);
      end
      MODE_EXPSIGN: begin
        r.cnt    = 2'd3;
        r.tok[0] = mk(KIND_NUMBER, ext(os), ext(e2 - os));
        r.tok[1] = mk(KIND_IDENT, ext(e2), LEN_ONE);
        r.tok[2] = mk(sg ? KIND_MINUS : KIND_PLUS, ext(e2) + LEN_ONE, LEN_ONE);
      end
      default: r.cnt = 2'd0;
    endcase
    return r;
  endfunction

  always_comb begin
    logic [2:0]    m;
    logic [PW-1:0] os;
    logic          sg;
    logic [PW-1:0] p;
    logic [PW-1:0] bp;
    logic [PW-1:0] e1;
    logic          keep;
    close_t        cr;
    bundle_t       nb;

    m    = mode;
    os   = open_start;
    sg   = pending_sign;
    p    = byte_position;
    bp   = byte_position;
    keep = 1'b0;
    nb   = '0;
    cr   = '0;
    e1   = ((p - os) >= POS_ONE) ? p - POS_ONE : os;

    if (has_char) begin
      case (m) inside
        MODE_IDENT: keep = is_letter(char_in) || is_digit(char_in);
        MODE_INT: begin
          if (is_digit(char_in)) begin
            keep = 1'b1;
          end else if (char_in == CH_DOT) begin
            m    = MODE_FRAC;
            keep = 1'b1;
          end else if (is_exp_mark(char_in)) begin
            m    = MODE_EXP;
            keep = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit(char_in)) begin
            keep = 1'b1;
          end else if (is_exp_mark(char_in)) begin
            m    = MODE_EXP;
            keep = 1'b1;
          end
        end
        MODE_EXP: begin
          if (is_digit(char_in)) begin
            m    = MODE_EXPDIG;
            keep = 1'b1;
          end else if ((char_in == CH_PLUS) || (char_in == CH_MINUS)) begin
            m    = MODE_EXPSIGN;
            sg   = (char_in == CH_MINUS);
            keep = 1'b1;
          end else if (is_letter(char_in)) begin
            // The mark turns out to begin an identifier.
            nb.tok[nb.cnt] = mk(KIND_NUMBER, ext(os), ext(e1 - os));
            nb.cnt         = nb.cnt + 3'd1;
            m              = MODE_IDENT;
            os             = e1;
            keep           = 1'b1;
          end
        end
        MODE_EXPSIGN, MODE_EXPDIG: begin
          if (is_digit(char_in)) begin
            m    = MODE_EXPDIG;
            keep = 1'b1;
          end
        end
        default: m = MODE_IDLE;
      endcase

      if (!keep) begin
        cr = close_fn(m, os, sg, p);
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < cr.cnt) begin
            nb.tok[nb.cnt] = cr.tok[i];
            nb.cnt         = nb.cnt + 3'd1;
          end
        end
        m = MODE_IDLE;
        if (is_blank(char_in)) begin
          m = MODE_IDLE;
        end else if (op_kind(char_in) != KIND_END) begin
          nb.tok[nb.cnt] = mk(op_kind(char_in), ext(p), LEN_ONE);
          nb.cnt         = nb.cnt + 3'd1;
        end else if (is_digit(char_in)) begin
          m  = MODE_INT;
          os = p;
        end else if (is_letter(char_in)) begin
          m  = MODE_IDENT;
          os = p;
        end else begin
          nb.tok[nb.cnt] = mk(KIND_UNKNOWN, ext(p), LEN_ONE);
          nb.cnt         = nb.cnt + 3'd1;
        end
      end

      if (p != POS_MAX) begin
        bp = p + POS_ONE;
      end
    end

    if (last) begin
      cr = close_fn(m, os, sg, bp);
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < cr.cnt) begin
          nb.tok[nb.cnt] = cr.tok[i];
          nb.cnt         = nb.cnt + 3'd1;
        end
      end
      nb.tok[nb.cnt] = mk(KIND_END, ext(bp), LEN_ZERO);
      nb.cnt         = nb.cnt + 3'd1;
      m              = MODE_IDLE;
      os             = POS_ZERO;
      bp             = POS_ZERO;
      sg             = 1'b0;
    end

    mode_next          = m;
    open_start_next    = os;
    byte_position_next = bp;
    pending_sign_next  = sg;
    bundle             = nb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      open_start    <= POS_ZERO;
      byte_position <= POS_ZERO;
      pending_sign  <= 1'b0;
    end else if (take) begin
      mode          <= mode_next;
      open_start    <= open_start_next;
      byte_position <= byte_position_next;
      pending_sign  <= pending_sign_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/exptok_outbuf.sv
// Result register that holds one beat's tokens and hands one out per cycle of token_ready.
`default_nettype none

module exptok_outbuf
  import exptok_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  bundle_t          bundle,
  input  wire logic        take,
  output logic             space,
  output logic             token_valid,
  input  wire logic        token_ready,
  output logic [3:0]       token_kind,
  output logic [15:0]      token_start,
  output logic [15:0]      token_length,
  output logic             run_last
);

  token_t [BUNDLE_DEPTH-1:0] tok;
  logic [2:0]                cnt;
  logic                      pop;

  assign pop          = (cnt != 3'd0) && token_ready;
  // Room for a new beat when empty or once the last held token leaves in this cycle.
  assign space        = (cnt == 3'd0) || ((cnt == 3'd1) && token_ready);
  assign token_valid  = (cnt != 3'd0);
  assign token_kind   = tok[0].kind;
  assign token_start  = tok[0].start;
  assign token_length = tok[0].length;
  assign run_last     = (cnt == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (take) begin
      cnt <= bundle.cnt;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok <= bundle.tok;
    end else if (pop) begin
      for (int i = 0; i < BUNDLE_DEPTH - 1; i++) begin
        tok[i] <= tok[i+1];
      end
      tok[BUNDLE_DEPTH-1] <= '0;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/expression_tokenizer_top.sv
// A beat's first token is registered and is on the output in the cycle after the
// beat is taken. While token_ready is high, one beat per cycle is taken while each
// beat yields at most one token; one that yields more holds the result register,
// one token per cycle until its last leaves; the register and its count set the rate.
// Reset clears the lexer to offset zero with no token open and drops held tokens.
`default_nettype none

module expression_tokenizer_top
  import exptok_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        char_valid,
  output logic             char_ready,
  input  wire logic [7:0]  char_in,
  input  wire logic        has_char,
  input  wire logic        last,
  output logic             token_valid,
  input  wire logic        token_ready,
  output logic [3:0]       token_kind,
  output logic [15:0]      token_start,
  output logic [15:0]      token_length,
  output logic             run_last
);

  bundle_t bundle;
  logic    take;

  assign take = char_valid && char_ready;

  exptok_lexer #(
    .POSITION_BITS(POSITION_BITS)
  ) u_lexer (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_in),
    .has_char (has_char),
    .last     (last),
    .take     (take),
    .bundle   (bundle)
  );

  exptok_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .bundle       (bundle),
    .take         (take),
    .space        (char_ready),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .run_last     (run_last)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/exptok_checker.sv
// Port-level checks on the tokenizer top level and the bind that attaches them.
`default_nettype none

`include "expression_tokenizer_top_macros.svh"

module exptok_checker
  import exptok_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        char_valid,
  input wire logic        char_ready,
  input wire logic        last,
  input wire logic        token_valid,
  input wire logic        token_ready,
  input wire logic [3:0]  token_kind,
  input wire logic [15:0] token_start,
  input wire logic [15:0] token_length,
  input wire logic        run_last
);

  logic [36:0] tok_word;

  assign tok_word = {token_kind, token_start, token_length, run_last};

  `EXPTOK_ASSERT_RST(a_reset_empty, rst, !token_valid)
  `EXPTOK_ASSERT_NEXT(a_out_hold, token_valid && !token_ready, token_valid && $stable(tok_word))
  `EXPTOK_ASSERT(a_end_closes, token_valid && (token_kind == KIND_END), (token_length == 16'd0) && run_last)
  `EXPTOK_ASSERT_NEXT(a_last_gives_token, char_valid && char_ready && last, token_valid)
  `EXPTOK_ASSERT(a_empty_ready, !token_valid, char_ready)

endmodule

bind expression_tokenizer_top exptok_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .char_valid   (char_valid),
  .char_ready   (char_ready),
  .last         (last),
  .token_valid  (token_valid),
  .token_ready  (token_ready),
  .token_kind   (token_kind),
  .token_start  (token_start),
  .token_length (token_length),
  .run_last     (run_last)
);

`default_nettype wire

FILE: verif/expression_tokenizer_top_test.sv
// Self-checking bench for the expression tokenizer: directed and random byte streams
// checked token by token against a lexer kept inside the bench.
module expression_tokenizer_top_test;
  import exptok_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] POS_MAX = (32'd1 << POSITION_BITS_DEFAULT) - 32'd1;
  localparam int LIMIT_CYCLES = 600_000;
  localparam int HOLD_OFF_CYCLES = 150;

  typedef enum logic [2:0] {
    LX_IDLE, LX_IDENT, LX_INT, LX_FRAC, LX_EXP, LX_EXPSIGN, LX_EXPDIG
  } lex_mode_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        run_last;
  } token_rec_t;

  typedef struct {
    logic [7:0]  ch;
    logic        has;
    logic        fin;
    int unsigned gap;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_ready;
  logic [7:0]  char_in = 8'h00;
  logic        has_char = 1'b0;
  logic        last = 1'b0;
  logic        token_valid;
  logic        token_ready = 1'b0;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        run_last;

  expression_tokenizer_top uut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_in      (char_in),
    .has_char     (has_char),
    .last         (last),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .run_last     (run_last)
  );

  always #6 clk = ~clk;

  // Lexer state of the bench.
  lex_mode_e   lx_mode;
  logic [31:0] lx_open;
  logic [31:0] lx_pos;
  logic        lx_minus;

  token_rec_t  tokens_due[$];
  beat_t       pending_beats[$];
  beat_t       cur_beat;
  logic        staged = 1'b0;
  int unsigned hold_left = 0;
  logic        gen_calm = 1'b0;
  logic        beat_in = 1'b0;
  logic        tok_taken = 1'b0;
  logic        stop_rx = 1'b0;
  logic        rx_calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned beats_taken = 0;
  int unsigned bad_tokens = 0;
  token_rec_t  got;
  token_rec_t  want;

  function automatic logic char_is_digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic char_is_word(logic [7:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z) || c == CH_UNDER;
  endfunction

  function automatic logic char_is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  // Kind of a byte that makes a token on its own: operators, brackets, anything else.
  function automatic logic [3:0] lone_kind(logic [7:0] c);
    case (c)
      CH_EQ:     return KIND_EQ;
      CH_PLUS:   return KIND_PLUS;
      CH_MINUS:  return KIND_MINUS;
      CH_STAR:   return KIND_STAR;
      CH_SLASH:  return KIND_SLASH;
      CH_CARET:  return KIND_CARET;
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      CH_LBRACK: return KIND_LBRACK;
      CH_RBRACK: return KIND_RBRACK;
      default:   return KIND_UNKNOWN;
    endcase
  endfunction

  function automatic void clear_lexer();
    lx_mode = LX_IDLE;
    lx_open = '0;
    lx_pos = '0;
    lx_minus = 1'b0;
  endfunction

  function automatic void add_token(logic [3:0] kind, logic [31:0] start, logic [31:0] len);
    token_rec_t t;
    t.kind = kind;
    t.start = start[15:0];
    t.length = len[15:0];
    t.run_last = 1'b0;
    tokens_due.push_back(t);
  endfunction

  // Steps back over the exponent mark (and sign), but never past the number's start.
  function automatic logic [31:0] back_off(logic [31:0] p, int n);
    return (p >= lx_open + n) ? p - n : lx_open;
  endfunction

  function automatic void close_open(logic [31:0] p);
    logic [31:0] e;
    case (lx_mode)
      LX_IDENT: add_token(KIND_IDENT, lx_open, p - lx_open);
      LX_INT, LX_FRAC, LX_EXPDIG: add_token(KIND_NUMBER, lx_open, p - lx_open);
      LX_EXP: begin
        e = back_off(p, 1);
        add_token(KIND_NUMBER, lx_open, e - lx_open);
        add_token(KIND_IDENT, e, 1);
      end
      LX_EXPSIGN: begin
        e = back_off(p, 2);
        add_token(KIND_NUMBER, lx_open, e - lx_open);
        add_token(KIND_IDENT, e, 1);
        add_token(lx_minus ? KIND_MINUS : KIND_PLUS, e + 1, 1);
      end
      default: ;
    endcase
    lx_mode = LX_IDLE;
  endfunction

  function automatic void open_from(logic [7:0] c, logic [31:0] p);
    if (char_is_blank(c)) return;
    if (char_is_digit(c)) begin
      lx_mode = LX_INT;
      lx_open = p;
    end else if (char_is_word(c)) begin
      lx_mode = LX_IDENT;
      lx_open = p;
    end else begin
      add_token(lone_kind(c), p, 1);
    end
  endfunction

  function automatic void lex_byte(logic [7:0] c, logic [31:0] p);
    logic        keep;
    logic [31:0] e;
    keep = 1'b0;
    case (lx_mode)
      LX_IDENT: keep = char_is_word(c) || char_is_digit(c);
      LX_INT, LX_FRAC: begin
        if (char_is_digit(c)) begin
          keep = 1'b1;
        end else if (c == CH_DOT && lx_mode == LX_INT) begin
          lx_mode = LX_FRAC;
          keep = 1'b1;
        end else if (c == CH_LC_E || c == CH_UC_E) begin
          lx_mode = LX_EXP;
          keep = 1'b1;
        end
      end
      LX_EXP: begin
        if (char_is_digit(c)) begin
          lx_mode = LX_EXPDIG;
          keep = 1'b1;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          lx_mode = LX_EXPSIGN;
          lx_minus = (c == CH_MINUS);
          keep = 1'b1;
        end else if (char_is_word(c)) begin
          // The mark turns out to open an identifier that goes on.
          e = back_off(p, 1);
          add_token(KIND_NUMBER, lx_open, e - lx_open);
          lx_mode = LX_IDENT;
          lx_open = e;
          keep = 1'b1;
        end
      end
      LX_EXPSIGN, LX_EXPDIG: begin
        if (char_is_digit(c)) begin
          lx_mode = LX_EXPDIG;
          keep = 1'b1;
        end
      end
      default: lx_mode = LX_IDLE;
    endcase
    if (!keep) begin
      close_open(p);
      open_from(c, p);
    end
  endfunction

  function automatic void tokenize_beat(logic [7:0] c, logic has, logic fin);
    int          due_prior;
    logic [31:0] p;
    token_rec_t  t;
    due_prior = tokens_due.size();
    if (has) begin
      p = lx_pos;
      lex_byte(c, p);
      if (p < POS_MAX) lx_pos = p + 1;
    end
    if (fin) begin
      close_open(lx_pos);
      add_token(KIND_END, lx_pos, 0);
      clear_lexer();
    end
    if (tokens_due.size() > due_prior) begin
      t = tokens_due.pop_back();
      t.run_last = 1'b1;
      tokens_due.push_back(t);
    end
  endfunction

  // Stimulus helpers.
  function automatic logic [7:0] op_char(int i);
    case (i)
      0:       return CH_EQ;
      1:       return CH_PLUS;
      2:       return CH_MINUS;
      3:       return CH_STAR;
      4:       return CH_SLASH;
      5:       return CH_CARET;
      6:       return CH_LPAREN;
      7:       return CH_RPAREN;
      8:       return CH_LBRACK;
      default: return CH_RBRACK;
    endcase
  endfunction

  function automatic logic [7:0] blank_char(int i);
    case (i)
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return CH_LC_A + 8'(r);
    if (r < 52) return CH_UC_A + 8'(r - 26);
    return CH_UNDER;
  endfunction

  task automatic queue_beat(logic [7:0] c, logic has, logic fin);
    beat_t b;
    b.ch = c;
    b.has = has;
    b.fin = fin;
    b.gap = gen_calm ? 0 : $urandom_range(0, 11);
    pending_beats.push_back(b);
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_beat(s[i], 1'b1, 1'b0);
  endtask

  // Digits, optional fraction, optional exponent that may be left unfinished.
  task automatic queue_number();
    repeat ($urandom_range(1, 4)) queue_beat(rand_digit(), 1'b1, 1'b0);
    if ($urandom_range(0, 1) == 1) begin
      queue_beat(CH_DOT, 1'b1, 1'b0);
      repeat ($urandom_range(0, 3)) queue_beat(rand_digit(), 1'b1, 1'b0);
    end
    if ($urandom_range(0, 4) < 2) begin
      queue_beat(($urandom_range(0, 1) == 1) ? CH_LC_E : CH_UC_E, 1'b1, 1'b0);
      if ($urandom_range(0, 1) == 1)
        queue_beat(($urandom_range(0, 1) == 1) ? CH_PLUS : CH_MINUS, 1'b1, 1'b0);
      repeat ($urandom_range(0, 2)) queue_beat(rand_digit(), 1'b1, 1'b0);
    end
  endtask

  task automatic queue_word();
    queue_beat(rand_letter(), 1'b1, 1'b0);
    repeat ($urandom_range(0, 5))
      queue_beat(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter(), 1'b1, 1'b0);
  endtask

  task automatic queue_expression();
    beat_t tail;
    gen_calm = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: queue_number();
        3, 4:    queue_word();
        5, 6:    queue_beat(op_char($urandom_range(0, 9)), 1'b1, 1'b0);
        7:       queue_beat(blank_char($urandom_range(0, 3)), 1'b1, 1'b0);
        8:       queue_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        default: queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      endcase
    end
    if ($urandom_range(0, 2) == 0) begin
      queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end else begin
      tail = pending_beats.pop_back();
      tail.fin = 1'b1;
      pending_beats.push_back(tail);
    end
  endtask

  // Sender: presents each queued beat after its gap and holds it until it is taken.
  always @(negedge clk) begin
    if (!rst && !(char_valid && !beat_in)) begin
      if (!staged && pending_beats.size() != 0) begin
        cur_beat = pending_beats.pop_front();
        staged = 1'b1;
        hold_left = cur_beat.gap;
      end
      if (staged && hold_left == 0) begin
        char_valid <= 1'b1;
        char_in <= cur_beat.ch;
        has_char <= cur_beat.has;
        last <= cur_beat.fin;
        staged = 1'b0;
      end else begin
        char_valid <= 1'b0;
        if (staged) hold_left--;
      end
    end
  end

  // Receiver: a random stall after every accepted token, plus the long hold-off.
  always @(negedge clk) begin
    if (!rst) begin
      if (tok_taken) begin
        if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
        stall_left = rx_calm ? 0 : $urandom_range(0, 11);
      end
      if (stop_rx || stall_left != 0) begin
        token_ready <= 1'b0;
        if (stall_left != 0) stall_left--;
      end else begin
        token_ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on every accepted input beat, then checks any accepted token.
  always @(posedge clk) begin
    beat_in <= ((char_valid && char_ready) === 1'b1);
    tok_taken <= ((token_valid && token_ready) === 1'b1);
    if (!rst && char_valid && char_ready) begin
      tokenize_beat(char_in, has_char, last);
      beats_taken++;
    end
    if (!rst && token_valid && token_ready) begin
      got = {token_kind, token_start, token_length, run_last};
      if (tokens_due.size() == 0) begin
        bad_tokens++;
        if (bad_tokens <= 10)
          $display("unexpected token: kind %0d start %0d length %0d run_last %0b",
                   got.kind, got.start, got.length, got.run_last);
      end else begin
        want = tokens_due.pop_front();
        if (got !== want) begin
          bad_tokens++;
          if (bad_tokens <= 10)
            $display("token mismatch: expected kind %0d start %0d length %0d run_last %0b,",
                     want.kind, want.start, want.length, want.run_last,
                     " got kind %0d start %0d length %0d run_last %0b",
                     got.kind, got.start, got.length, got.run_last);
        end
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering beats.
  initial begin
    while (beats_taken < 80) @(posedge clk);
    stop_rx = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    stop_rx = 1'b0;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    clear_lexer();
    gen_calm = 1'b0;
    // Directed: every operator, unfinished exponents with and without sign,
    // an exponent mark that goes on as an identifier, byte extremes, an empty
    // beat, and an end beat without a byte that closes a dangling mark.
    queue_text("=+-*/^()[]");
    queue_text(" 3.5E-x");
    queue_text("1ez");
    queue_beat(8'h00, 1'b1, 1'b0);
    queue_beat(8'hFF, 1'b1, 1'b0);
    queue_beat(8'h00, 1'b0, 1'b0);
    queue_text("4e");
    queue_beat(8'hFF, 1'b0, 1'b1);

    while (pending_beats.size() < 160) queue_expression();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || staged || char_valid || tokens_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (bad_tokens == 0 && tokens_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: expression_tokenizer_top.f
+incdir+hw/rtl
hw/rtl/exptok_pkg.sv
hw/rtl/exptok_lexer.sv
hw/rtl/exptok_outbuf.sv
hw/rtl/expression_tokenizer_top.sv
hw/rtl/exptok_checker.sv
verif/expression_tokenizer_top_test.sv
